// ===== sv/hnd_pkg.sv =====
// Package for the HPACK Huffman nibble decoder: result kinds, bundle types and
// the code tree, nibble transition table and end-acceptance table built at elaboration.
// No dependencies.
package hnd_pkg;

    localparam int SymCount  = 257;
    localparam int EosSym    = 256;
    localparam int NodeCount = 256;
    localparam int MaxLen    = 30;
    localparam int LeafFlag  = 512;
    localparam int NibCount  = 16;

    localparam logic [1:0] KIND_SYM  = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    localparam logic [4:0] CodeLen [SymCount] = '{
        5'd13,5'd23,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd28,5'd24,5'd30,5'd28,5'd28,5'd30,5'd28,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd30,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd6,5'd10,5'd10,5'd12,5'd13,5'd6,5'd8,5'd11,
        5'd10,5'd10,5'd8,5'd11,5'd8,5'd6,5'd6,5'd6,
        5'd5,5'd5,5'd5,5'd6,5'd6,5'd6,5'd6,5'd6,
        5'd6,5'd6,5'd7,5'd8,5'd15,5'd6,5'd12,5'd10,
        5'd13,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd8,5'd7,5'd8,5'd13,5'd19,5'd13,5'd14,5'd6,
        5'd15,5'd5,5'd6,5'd5,5'd6,5'd5,5'd6,5'd6,
        5'd6,5'd5,5'd7,5'd7,5'd6,5'd6,5'd6,5'd5,
        5'd6,5'd7,5'd6,5'd5,5'd5,5'd6,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd15,5'd11,5'd14,5'd13,5'd28,
        5'd20,5'd22,5'd20,5'd20,5'd22,5'd22,5'd22,5'd23,
        5'd22,5'd23,5'd23,5'd23,5'd23,5'd23,5'd24,5'd23,
        5'd24,5'd24,5'd22,5'd23,5'd24,5'd23,5'd23,5'd23,
        5'd23,5'd21,5'd22,5'd23,5'd22,5'd23,5'd23,5'd24,
        5'd22,5'd21,5'd20,5'd22,5'd22,5'd23,5'd23,5'd21,
        5'd23,5'd22,5'd22,5'd24,5'd21,5'd22,5'd23,5'd23,
        5'd21,5'd21,5'd22,5'd21,5'd23,5'd22,5'd23,5'd23,
        5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,5'd22,5'd23,
        5'd26,5'd26,5'd20,5'd19,5'd22,5'd23,5'd22,5'd25,
        5'd26,5'd26,5'd26,5'd27,5'd27,5'd26,5'd24,5'd25,
        5'd19,5'd21,5'd26,5'd27,5'd27,5'd26,5'd27,5'd24,
        5'd21,5'd21,5'd26,5'd26,5'd28,5'd27,5'd27,5'd27,
        5'd20,5'd24,5'd20,5'd21,5'd22,5'd21,5'd21,5'd23,
        5'd22,5'd22,5'd25,5'd25,5'd24,5'd24,5'd26,5'd23,
        5'd26,5'd27,5'd26,5'd26,5'd27,5'd27,5'd27,5'd27,
        5'd27,5'd28,5'd27,5'd27,5'd27,5'd27,5'd27,5'd26,
        5'd30
    };

    // child entry: 0 absent, LeafFlag|sym leaf, else internal node
    typedef struct packed {
        logic [NodeCount-1:0][1:0][9:0] child;
        logic [NodeCount-1:0][7:0]      depth;
        logic [NodeCount-1:0]           ones;
    } tree_t;

    typedef struct packed {
        logic       emit;
        logic       fail;
        logic [7:0] sym;
        logic [7:0] next;
    } nib_ent_t;

    typedef nib_ent_t [NodeCount*NibCount-1:0] nib_tab_t;

    typedef struct packed {
        logic [7:0] sym;
        logic [1:0] kind;
    } res_t;

    typedef struct packed {
        logic [1:0]       cnt;
        res_t [2:0]       slot;
    } bundle_t;

    function automatic tree_t build_tree();
        tree_t       t;
        int unsigned code;
        int unsigned used;
        int unsigned node;
        int unsigned c;
        int unsigned bv;
        bit          done;
        t    = '0;
        t.ones[0] = 1'b1;
        code = 0;
        used = 1;
        for (int len = 1; len <= MaxLen; len++) begin
            for (int s = 0; s < SymCount; s++) begin
                if (int'(CodeLen[s]) == len) begin
                    node = 0;
                    done = 1'b0;
                    for (int b = len; b > 0; b--) begin
                        if (!done) begin
                            bv = (code >> (b - 1)) & 1;
                            c  = int'(t.child[node][bv]);
                            if (b == 1) begin
                                if (c == 0)
                                    t.child[node][bv] = 10'(LeafFlag | s);
                                done = 1'b1;
                            end else if ((c & LeafFlag) != 0) begin
                                done = 1'b1;
                            end else begin
                                if (c == 0) begin
                                    if (used >= NodeCount) begin
                                        done = 1'b1;
                                    end else begin
                                        c    = used;
                                        used = used + 1;
                                        t.child[node][bv] = 10'(c);
                                        t.depth[c] = t.depth[node] + 8'd1;
                                        t.ones[c]  = t.ones[node] && (bv == 1);
                                    end
                                end
                                if (!done)
                                    node = c & 255;
                            end
                        end
                    end
                    code = code + 1;
                end
            end
            code = code << 1;
        end
        return t;
    endfunction

    function automatic nib_tab_t build_nib_table(tree_t t);
        nib_tab_t    tab;
        int unsigned node;
        int unsigned c;
        int unsigned bv;
        bit          emit;
        bit          fail;
        int unsigned sym;
        tab = '0;
        for (int n = 0; n < NodeCount; n++) begin
            for (int v = 0; v < NibCount; v++) begin
                node = n;
                emit = 1'b0;
                fail = 1'b0;
                sym  = 0;
                for (int i = 3; i >= 0; i--) begin
                    if (!fail) begin
                        bv = (v >> i) & 1;
                        c  = int'(t.child[node][bv]);
                        if ((c & LeafFlag) != 0) begin
                            if ((c & 511) == EosSym) begin
                                fail = 1'b1;
                            end else begin
                                emit = 1'b1;
                                sym  = c & 255;
                                node = 0;
                            end
                        end else if (c == 0) begin
                            fail = 1'b1;
                        end else begin
                            node = c & 255;
                        end
                    end
                end
                tab[n*NibCount+v].emit = emit;
                tab[n*NibCount+v].fail = fail;
                tab[n*NibCount+v].sym  = 8'(sym);
                tab[n*NibCount+v].next = fail ? 8'd0 : 8'(node);
            end
        end
        return tab;
    endfunction

    function automatic logic [NodeCount-1:0] build_end_ok(tree_t t);
        logic [NodeCount-1:0] ok;
        for (int n = 0; n < NodeCount; n++)
            ok[n] = t.ones[n] && (t.depth[n] < 8'd8);
        return ok;
    endfunction

    localparam tree_t                Tree     = build_tree();
    localparam nib_tab_t             NibTable = build_nib_table(Tree);
    localparam logic [NodeCount-1:0] EndOk    = build_end_ok(Tree);

endpackage

// ===== sv/hnd_step.sv =====
// Decode step for one coded byte: two nibble table lookups, end check, result bundle.
// Depends on hnd_pkg.
module hnd_step
    import hnd_pkg::*;
(
    input  logic [7:0] state,
    input  logic       failed,
    input  logic [7:0] code_byte,
    input  logic       string_end,
    output logic [7:0] state_next,
    output logic       failed_next,
    output bundle_t    bundle
);

    nib_ent_t   hi_ent;
    nib_ent_t   lo_ent;
    logic       emit_hi;
    logic       emit_lo;
    logic       fail_any;
    logic [7:0] state_dec;
    logic [1:0] cnt;

    always_comb
    begin
        hi_ent = NibTable[{state, code_byte[7:4]}];
        lo_ent = NibTable[{hi_ent.next, code_byte[3:0]}];

        emit_hi  = !failed && hi_ent.emit;
        emit_lo  = !failed && !hi_ent.fail && lo_ent.emit;
        fail_any = failed || hi_ent.fail || lo_ent.fail;
        if (failed)
            state_dec = state;
        else if (hi_ent.fail)
            state_dec = 8'd0;
        else
            state_dec = lo_ent.next;

        bundle = '0;
        cnt    = 2'd0;
        if (emit_hi)
        begin
            bundle.slot[cnt] = '{sym: hi_ent.sym, kind: KIND_SYM};
            cnt = cnt + 2'd1;
        end
        if (emit_lo)
        begin
            bundle.slot[cnt] = '{sym: lo_ent.sym, kind: KIND_SYM};
            cnt = cnt + 2'd1;
        end
        if (string_end)
        begin
            bundle.slot[cnt].sym  = 8'd0;
            bundle.slot[cnt].kind = (!fail_any && EndOk[state_dec]) ? KIND_OK : KIND_FAIL;
            cnt = cnt + 2'd1;
        end
        bundle.cnt = cnt;

        // end of string: drop back to the root with the failure cleared
        state_next  = string_end ? 8'd0 : state_dec;
        failed_next = string_end ? 1'b0 : fail_any;
    end

endmodule

// ===== sv/hnd_out.sv =====
// Result register: holds one byte's bundle of up to three results and hands them out
// one beat at a time. Depends on hnd_pkg.
module hnd_out
    import hnd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  bundle_t    bundle_in,
    output logic       can_load,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] symbol,
    output logic [1:0] kind,
    output logic       run_last
);

    logic [1:0] cnt_reg;
    res_t [2:0] slot_reg;
    logic [1:0] idx_reg;
    logic       at_last;

    assign out_valid = (cnt_reg != 2'd0);
    assign at_last   = (idx_reg == cnt_reg - 2'd1);
    assign can_load  = !out_valid || (out_ready && at_last);
    assign symbol    = slot_reg[idx_reg].sym;
    assign kind      = slot_reg[idx_reg].kind;
    assign run_last  = at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= bundle_in.cnt;
            idx_reg <= 2'd0;
        end
        else if (out_valid && out_ready)
        begin
            if (at_last)
                cnt_reg <= 2'd0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= bundle_in.slot;
    end

endmodule

// ===== sv/hpack_huffman_nibble_decoder_core.sv =====
// An accepted byte waits in the input register until the result register can take it,
// and its first result beat is offered once it has moved into the result register.
// Throughput: one byte per cycle with out_ready high and at most one result per byte;
// a byte with k results (up to three) keeps the result register until all are taken.
// Reset: rst_n is asynchronous, active low; empties the input and result registers,
// the tree node state (root) and the sticky failure flag.
module hpack_huffman_nibble_decoder_core
    import hnd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] code_byte,
    input  logic       string_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] symbol,
    output logic [1:0] kind,
    output logic       run_last
);

    // input register: holds one accepted beat until the result register can take it
    logic       in_full_reg;
    logic [7:0] byte_reg;
    logic       end_reg;

    // decoder state: current node of the code tree and sticky failure
    logic [7:0] state_reg;
    logic       failed_reg;
    logic [7:0] state_next;
    logic       failed_next;

    bundle_t    bundle;
    logic       can_load;
    logic       advance;

    // move the held byte on whenever the result register frees up this cycle
    assign advance  = in_full_reg && can_load;
    assign in_ready = !in_full_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            state_reg   <= 8'd0;
            failed_reg  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_full_reg <= 1'b1;
            else if (advance)
                in_full_reg <= 1'b0;
            // state advances once per byte, as the byte leaves the input register
            if (advance)
            begin
                state_reg  <= state_next;
                failed_reg <= failed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= code_byte;
            end_reg  <= string_end;
        end
    end

    hnd_step u_step (
        .state       (state_reg),
        .failed      (failed_reg),
        .code_byte   (byte_reg),
        .string_end  (end_reg),
        .state_next  (state_next),
        .failed_next (failed_next),
        .bundle      (bundle)
    );

    hnd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .bundle_in (bundle),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .kind      (kind),
        .run_last  (run_last)
    );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for hpack_huffman_nibble_decoder_core: streams coded
// strings (well-formed, broken and random) and checks every result beat.
// Depends on hnd_pkg (code lengths, result kinds) and the decoder RTL.
module testbench;
    import hnd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAF     = 512;
    localparam int IDLE_MAX = 2000;

    typedef struct {
        logic [7:0] symbol;
        logic [1:0] kind;
        logic       run_last;
    } octet_beat_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] code_byte;
    logic       string_end;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] symbol;
    logic [1:0] kind;
    logic       run_last;

    hpack_huffman_nibble_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .code_byte (code_byte),
        .string_end(string_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .kind      (kind),
        .run_last  (run_last)
    );

    // Our own copy of the canonical code tree and the codeword of each symbol.
    int          node_child [NodeCount][2];
    int          node_depth [NodeCount];
    bit          node_ones  [NodeCount];
    int unsigned sym_code   [SymCount];
    int          sym_len    [SymCount];

    // Decoder state as predicted.
    int          walk_node;
    bit          walk_dead;

    octet_beat_t decoded_q [$];
    int          errors;
    int          bytes_sent;
    int          strings_sent;
    int          beats_seen;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;
    event        byte_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Build the tree from the canonical code lengths: codes of one length are
    // consecutive, and the code shifts left when moving to the next length.
    task automatic build_code_tree();
        int unsigned code;
        int          used;
        int          node;
        int          c;
        int          b;
        int          bv;
        code = 0;
        used = 1;
        for (int n = 0; n < NodeCount; n++)
        begin
            node_child[n][0] = 0;
            node_child[n][1] = 0;
            node_depth[n]    = 0;
            node_ones[n]     = 1'b0;
        end
        node_ones[0] = 1'b1;
        for (int len = 1; len <= MaxLen; len++)
        begin
            for (int s = 0; s < SymCount; s++)
            begin
                if (int'(CodeLen[s]) == len)
                begin
                    sym_code[s] = code;
                    sym_len[s]  = len;
                    node = 0;
                    for (b = len; b > 0; b--)
                    begin
                        bv = (code >> (b - 1)) & 1;
                        c  = node_child[node][bv];
                        if (b == 1)
                        begin
                            if (c == 0)
                                node_child[node][bv] = LEAF | s;
                            break;
                        end
                        if ((c & LEAF) != 0)
                            break;
                        if (c == 0)
                        begin
                            c = used;
                            used++;
                            node_child[node][bv] = c;
                            node_depth[c] = node_depth[node] + 1;
                            node_ones[c]  = node_ones[node] && (bv == 1);
                        end
                        node = c;
                    end
                    code++;
                end
            end
            code = code << 1;
        end
    endtask

    function automatic void push_beat(logic [7:0] s, logic [1:0] k);
        octet_beat_t r;
        r.symbol   = s;
        r.kind     = k;
        r.run_last = 1'b0;
        decoded_q.push_back(r);
    endfunction

    // Walk both nibbles of one accepted byte; queue the octets and end beat.
    function automatic void predict_byte(logic [7:0] b, logic last);
        int start_size;
        int nib;
        int node;
        int c;
        bit ok;
        start_size = decoded_q.size();
        for (int half = 0; half < 2 && !walk_dead; half++)
        begin
            nib  = half == 0 ? b[7:4] : b[3:0];
            node = walk_node;
            for (int i = 3; i >= 0; i--)
            begin
                c = node_child[node][(nib >> i) & 1];
                if ((c & LEAF) != 0)
                begin
                    if ((c & 511) == EosSym)
                    begin
                        walk_dead = 1'b1;
                        break;
                    end
                    push_beat(8'(c & 255), KIND_SYM);
                    node = 0;
                end
                else if (c == 0)
                begin
                    walk_dead = 1'b1;
                    break;
                end
                else
                    node = c;
            end
            walk_node = walk_dead ? 0 : node;
        end
        if (last)
        begin
            ok = !walk_dead && node_ones[walk_node] && node_depth[walk_node] < 8;
            push_beat(8'd0, ok ? KIND_OK : KIND_FAIL);
            walk_node = 0;
            walk_dead = 1'b0;
        end
        if (decoded_q.size() > start_size)
            decoded_q[decoded_q.size() - 1].run_last = 1'b1;
    endfunction

    // Send one byte: optional idle gap, then hold valid until the beat is taken.
    task automatic send_byte(logic [7:0] b, logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid   = 1'b0;
            code_byte  = 8'($urandom);
            string_end = 1'($urandom);
            @(negedge clk);
        end
        in_valid   = 1'b1;
        code_byte  = b;
        string_end = last;
        @(byte_taken);
    endtask

    // Encode symbols, pad with ones to a byte, optionally spoil the stream.
    // spoil: 0 none, 1 insert EOS, 2 extra all-ones byte, 3 zero padding
    task automatic send_string(int syms[$], int spoil);
        bit bits [$];
        int nbytes;
        logic [7:0] b;
        foreach (syms[k])
        begin
            if (spoil == 1 && k == syms.size() / 2)
                for (int i = 0; i < sym_len[EosSym]; i++)
                    bits.push_back(1'b1);
            for (int i = sym_len[syms[k]] - 1; i >= 0; i--)
                bits.push_back((sym_code[syms[k]] >> i) & 1);
        end
        while (bits.size() % 8 != 0)
            bits.push_back(spoil == 3 ? 1'b0 : 1'b1);
        if (spoil == 2)
            for (int i = 0; i < 8; i++)
                bits.push_back(1'b1);
        if (bits.size() == 0)
            for (int i = 0; i < 8; i++)
                bits.push_back(1'b1);
        nbytes = bits.size() / 8;
        for (int j = 0; j < nbytes; j++)
        begin
            for (int i = 0; i < 8; i++)
                b[7 - i] = bits[j * 8 + i];
            send_byte(b, j == nbytes - 1);
        end
    endtask

    task automatic test_directed();
        int s [$];
        send_byte(8'hff, 1'b1);             // eight ones of padding: rejected
        send_byte(8'h00, 1'b1);             // '0' then zero padding: rejected
        send_byte(8'h07, 1'b1);             // '0' then three ones: accepted
        s = '{97, 98, 99};
        send_string(s, 0);
        s = '{48, 49, 50, 97};              // three short codes per pair of bytes
        send_string(s, 0);
        s = '{0, 255, 10, 13};              // long codes, among them the longest
        send_string(s, 0);
        s = '{104, 105, 106};
        send_string(s, 1);                  // EOS inside the string
        s = '{120};
        send_string(s, 2);                  // padding of a full byte
        s = '{33, 34};
        send_string(s, 3);                  // zero padding
        send_byte(8'hff, 1'b0);             // bytes after a failure stay silent
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h5a, 1'b1);
        send_byte(8'h00, 1'b0);             // a string spanning bytes of zeros
        send_byte(8'h00, 1'b1);
    endtask

    // Mostly well-formed strings with random content, some spoiled, some noise.
    task automatic test_random_strings(int byte_goal);
        int s [$];
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < byte_goal)
        begin
            s = {};
            repeat ($urandom_range(1, 6))
                s.push_back($urandom_range(3) == 0 ? $urandom_range(255)
                                                   : $urandom_range(32, 126));
            pick = $urandom_range(9);
            if (pick < 6)
                send_string(s, 0);
            else if (pick < 9)
                send_string(s, pick - 5);
            else
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom), 1'($urandom_range(3) == 0));
        end
    endtask

    // Receiver stall, changed at the falling edge.
    always @(negedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

    // Predict the results of each input beat at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predict_byte(code_byte, string_end);
            bytes_sent++;
            if (string_end)
                strings_sent++;
            -> byte_taken;
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            beats_seen++;
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected beat symbol=%0h kind=%0d run_last=%0b",
                         $realtime, symbol, kind, run_last);
                errors++;
            end
            else
            begin
                if (symbol !== decoded_q[0].symbol || kind !== decoded_q[0].kind ||
                    run_last !== decoded_q[0].run_last)
                begin
                    $display("%0t: expected sym=%0h kind=%0d last=%0b got %0h %0d %0b",
                             $realtime, decoded_q[0].symbol, decoded_q[0].kind,
                             decoded_q[0].run_last, symbol, kind, run_last);
                    errors++;
                end
                void'(decoded_q.pop_front());
            end
        end
    end

    // Watchdog: give up after a long stretch with no beat moving either way.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_MAX)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        code_byte      = 8'h00;
        string_end     = 1'b0;
        errors         = 0;
        bytes_sent     = 0;
        strings_sent   = 0;
        beats_seen     = 0;
        quiet_cycles   = 0;
        walk_node      = 0;
        walk_dead      = 1'b0;
        send_idle_pct  = 16;
        recv_stall_pct = 54;
        build_code_tree();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_strings(65);
        send_idle_pct  = 54;
        recv_stall_pct = 16;
        test_random_strings(65);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_strings(70);

        @(negedge clk);
        in_valid = 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes in %0d strings, checked %0d result beats",
                 bytes_sent, strings_sent, beats_seen);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
